/* src/ssll_pkg.sv */
// ----------------------------------------------------------------------------
// ssll_pkg
// Shared constants, codes and control structs of the sorted linked list.
// ----------------------------------------------------------------------------
package ssll_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int PTR_W   = IDX_W + 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;

	// Field widths of the stream words.
	localparam int REQ_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int POS_W       = 6;
	localparam int SIZE_W      = 7;
	localparam int IN_FIELDS_W = REQ_W + KEY_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + POS_W + SIZE_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// A pointer at or above ENTRIES marks the end of a chain.
	localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic load_req;
		logic walk_init;
		logic walk_step;
		logic decide;
		logic free_rd;
		logic wr1;
		logic wr2;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic head_valid;
		logic walk_adv;
		logic do_ins;
		logic do_del;
		logic out_free;
	} dp_sts_t;

endpackage

/* src/ssll_ctrl.sv */
// ----------------------------------------------------------------------------
// ssll_ctrl
// Sequencer of the sorted linked list: walk, decision and link updates.
// ----------------------------------------------------------------------------
module ssll_ctrl
	import ssll_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_FREERD = 3'd4;
	localparam logic [2:0] S_WR1    = 3'd5;
	localparam logic [2:0] S_WR2    = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				// A full store refuses an insert before any walk.
				if (sts.full) begin
					state_d = S_DECIDE;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = sts.head_valid ? S_WALK : S_DECIDE;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (!sts.walk_adv) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.do_ins) begin
					state_d = S_FREERD;
				end else if (sts.do_del) begin
					state_d = S_WR1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FREERD: begin
				cmd.free_rd = 1'b1;
				state_d     = S_WR1;
			end
			S_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = S_WR2;
			end
			S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/ssll_datapath.sv */
// ----------------------------------------------------------------------------
// ssll_datapath
// Node memories, list pointers, walk registers and the result register.
// ----------------------------------------------------------------------------
module ssll_datapath
	import ssll_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               cmd,
	output dp_sts_t                sts,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic signed [KEY_W-1:0] key_mem [ENTRIES];
	logic [PTR_W-1:0]        next_mem [ENTRIES];
	logic [ENTRIES-1:0]      nvld_q;

	logic [REQ_W-1:0]        req_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PTR_W-1:0]        list_head_q;
	logic [PTR_W-1:0]        free_head_q;
	logic [CNT_W-1:0]        count_q;
	logic [PTR_W-1:0]        cur_q;
	logic [PTR_W-1:0]        prev_q;
	logic [PTR_W-1:0]        cur_next_q;
	logic                    found_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [IDX_W-1:0]        res_pos_q;
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;

	logic signed [KEY_W-1:0] key_rd_q;
	logic [PTR_W-1:0]        next_mem_rd_q;
	logic                    nvld_rd_q;
	logic [IDX_W-1:0]        raddr_q;

	logic [IDX_W-1:0] raddr;
	logic [PTR_W-1:0] next_rd;
	logic             less;
	logic             next_ok;
	logic             is_ins;
	logic             is_del;
	logic             free_ok;
	logic             prev_ok;
	logic             next_we;
	logic [IDX_W-1:0] next_wa;
	logic [PTR_W-1:0] next_wd;
	logic             key_we;

	// An entry never written still holds its reset link to the following node.
	assign next_rd = nvld_rd_q ? next_mem_rd_q : ({1'b0, raddr_q} + PTR_W'(1));
	assign less    = key_rd_q < key_q;
	assign next_ok = next_rd < NIL;
	assign is_ins  = (req_q == REQ_INSERT);
	assign is_del  = (req_q == REQ_DELETE);
	assign free_ok = free_head_q < NIL;
	assign prev_ok = prev_q < NIL;

	assign sts.full       = is_ins && !free_ok;
	assign sts.head_valid = list_head_q < NIL;
	assign sts.walk_adv   = less && next_ok;
	assign sts.do_ins     = is_ins && free_ok && !found_q;
	assign sts.do_del     = is_del && found_q;
	assign sts.out_free   = !out_valid_q || m_tready;

	always_comb begin
		raddr = '0;
		if (cmd.walk_init) begin
			raddr = list_head_q[IDX_W-1:0];
		end else if (cmd.walk_step) begin
			raddr = next_rd[IDX_W-1:0];
		end else if (cmd.free_rd) begin
			raddr = free_head_q[IDX_W-1:0];
		end
	end

	// Write port of the link memory: at most one link changes per cycle.
	always_comb begin
		next_we = 1'b0;
		next_wa = '0;
		next_wd = '0;
		key_we  = 1'b0;
		if (cmd.wr1) begin
			if (is_ins) begin
				key_we  = 1'b1;
				next_we = 1'b1;
				next_wa = res_pos_q;
				next_wd = cur_q;
			end else if (prev_ok) begin
				next_we = 1'b1;
				next_wa = prev_q[IDX_W-1:0];
				next_wd = cur_next_q;
			end
		end else if (cmd.wr2) begin
			if (is_ins) begin
				if (prev_ok) begin
					next_we = 1'b1;
					next_wa = prev_q[IDX_W-1:0];
					next_wd = {1'b0, res_pos_q};
				end
			end else begin
				next_we = 1'b1;
				next_wa = cur_q[IDX_W-1:0];
				next_wd = free_head_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[res_pos_q] <= key_q;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		key_rd_q      <= key_mem[raddr];
		next_mem_rd_q <= next_mem[raddr];
		nvld_rd_q     <= nvld_q[raddr];
		raddr_q       <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvld_q <= '0;
		end else if (next_we) begin
			nvld_q[next_wa] <= 1'b1;
		end
	end

	// Request and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= s_tdata[REQ_W-1:0];
			key_q <= s_tdata[REQ_W +: KEY_W];
		end
		if (cmd.walk_init) begin
			cur_q   <= list_head_q;
			prev_q  <= NIL;
			found_q <= 1'b0;
		end else if (cmd.walk_step) begin
			if (less) begin
				prev_q <= cur_q;
				cur_q  <= next_rd;
				if (!next_ok) begin
					found_q <= 1'b0;
				end
			end else begin
				found_q    <= (key_rd_q == key_q);
				cur_next_q <= next_rd;
			end
		end
		if (cmd.decide) begin
			if (is_ins) begin
				if (!free_ok) begin
					res_status_q <= ST_FULL;
					res_pos_q    <= '0;
				end else if (found_q) begin
					res_status_q <= ST_DUPLICATE;
					res_pos_q    <= '0;
				end else begin
					res_status_q <= ST_OK;
					res_pos_q    <= free_head_q[IDX_W-1:0];
				end
			end else if (found_q) begin
				res_status_q <= ST_OK;
				res_pos_q    <= cur_q[IDX_W-1:0];
			end else begin
				res_status_q <= ST_NOT_FOUND;
				res_pos_q    <= '0;
			end
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_TDATA_W'({SIZE_W'(count_q), POS_W'(res_pos_q), res_status_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q <= NIL;
			free_head_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				if (sts.do_ins) begin
					count_q <= count_q + CNT_W'(1);
				end else if (sts.do_del) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (cmd.wr1) begin
				if (is_ins) begin
					free_head_q <= next_rd;
				end else if (!prev_ok) begin
					list_head_q <= cur_next_q;
				end
			end
			if (cmd.wr2) begin
				if (is_ins) begin
					if (!prev_ok) begin
						list_head_q <= {1'b0, res_pos_q};
					end
				end else begin
					free_head_q <= cur_q;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* src/sorted_static_linked_list_top.sv */
// ----------------------------------------------------------------------------
// sorted_static_linked_list_top
// Sorted list of signed keys in a fixed node store with a free list.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word contents (lowest bit first)
//  s_*      in         req_type[1:0], key[33:2], zero pad to 40 bits
//  m_*      out        status[1:0], position[7:2], list_size[14:8], zero pad
//
// A request walks the linked nodes in order, reading one node per cycle from
// the node memory; an insert then reads the free list head and makes two link
// updates, and a delete makes two link updates.
// Reset leaves the list empty and the free list chained in index order; there
// is no clearing pass. A word is accepted only while the block is idle, and a
// finished word waits in the output register while the next one is accepted.
// ----------------------------------------------------------------------------
module sorted_static_linked_list_top
	import ssll_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // req_type, key
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // status, position, list_size
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	ssll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssll_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
